[src/gif_lzw_pixel_decoder_assert.svh]
// Assertion macros for the GIF LZW pixel decoder.
`ifndef GIF_LZW_PIXEL_DECODER_ASSERT_SVH
`define GIF_LZW_PIXEL_DECODER_ASSERT_SVH

// same-cycle implication
`define GIFD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gifd assertion failed");

// next-cycle implication
`define GIFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gifd assertion failed");

`endif

[src/gifd_pkg.sv]
// Shared types and constants of the GIF LZW pixel decoder.
package gifd_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int CODE_W = 13;

  localparam logic [1:0] CFG_MIN_CODE = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_ILACE    = 2'd3;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_PULL  = 2'd1,
    REQ_START = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_TAKEN   = 3'd2,
    ST_REFUSED = 3'd3,
    ST_END     = 3'd4,
    ST_ERROR   = 3'd5,
    ST_STARTED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXP_RD,
    S_EXP_WR,
    S_TABLE_WR,
    S_POP_RD,
    S_POP,
    S_DELIVER
  } state_e;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       take;
    logic [3:0] width;
  } bb_ctl_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pix;
    logic [15:0] col;
    logic [15:0] row;
    logic        last;
  } res_t;

  function automatic logic [15:0] pass_start(input logic [1:0] p);
    unique case (p)
      2'd0: pass_start = 16'd0;
      2'd1: pass_start = 16'd4;
      2'd2: pass_start = 16'd2;
      default: pass_start = 16'd1;
    endcase
  endfunction

  function automatic logic [3:0] pass_step(input logic [1:0] p);
    unique case (p)
      2'd0, 2'd1: pass_step = 4'd8;
      2'd2: pass_step = 4'd4;
      default: pass_step = 4'd2;
    endcase
  endfunction

endpackage

[src/gifd_ram.sv]
// Generic single-port-write, registered-read RAM.
module gifd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[src/gifd_bitbuf.sv]
// LSB-first bit buffer with the code extraction shifter.
module gifd_bitbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gifd_pkg::bb_ctl_t ctl_i,
  input  logic [7:0]       byte_i,
  output logic [11:0]      code_o,
  output logic [5:0]       count_o
);
  import gifd_pkg::*;

  logic [31:0] bits_q, bits_d;
  logic [5:0]  cnt_q, cnt_d;

  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    if (ctl_i.clear) begin
      bits_d = '0;
      cnt_d  = '0;
    end else if (ctl_i.load) begin
      bits_d = bits_q | (32'(byte_i) << cnt_q[4:0]);
      cnt_d  = cnt_q + 6'd8;
    end else if (ctl_i.take) begin
      bits_d = bits_q >> ctl_i.width;
      cnt_d  = cnt_q - {2'b00, ctl_i.width};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

  assign code_o  = bits_q[11:0] & ((12'(1) << ctl_i.width) - 12'(1));
  assign count_o = cnt_q;
endmodule

[src/gifd_raster.sv]
// Pixel column/row tracking with plain or interlaced row order.
module gifd_raster (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        step_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic        interlaced_i,
  output logic [15:0] col_o,
  output logic [15:0] row_o,
  output logic        last_o
);
  import gifd_pkg::*;

  logic [15:0] col_q, col_d, row_q, row_d;
  logic [2:0]  pass_q, pass_d;
  logic [16:0] w, h, col1, r;
  logic        fin;

  always_comb begin
    w      = (width_i == 16'd0) ? 17'd1 : {1'b0, width_i};
    h      = (height_i == 16'd0) ? 17'd1 : {1'b0, height_i};
    col1   = {1'b0, col_q} + 17'd1;
    col_d  = col_q;
    row_d  = row_q;
    pass_d = pass_q;
    fin    = 1'b0;
    r      = '0;
    if (col1 < w) begin
      col_d = col1[15:0];
    end else begin
      col_d = '0;
      if (interlaced_i) begin
        r = {1'b0, row_q} + 17'(pass_step(pass_q[1:0]));
        for (int i = 0; i < 4; i++) begin
          if (!fin && r >= h) begin
            pass_d = pass_d + 3'd1;
            if (pass_d > 3'd3) fin = 1'b1;
            else r = 17'(pass_start(pass_d[1:0]));
          end
        end
      end else begin
        r = {1'b0, row_q} + 17'd1;
        fin = (r >= h);
      end
      if (!fin) row_d = r[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else if (clear_i) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else if (step_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

  assign col_o  = col_q;
  assign row_o  = row_q;
  assign last_o = fin;
endmodule

[src/gif_lzw_pixel_decoder.sv]
// Top level of the GIF LZW pixel decoder.
// Usage:
//   One request per input transaction (req_type_i, data_byte_i): push a
//   sub-block byte, pull one pixel, or start a new frame. Each request gives
//   exactly one output transaction: status_o with pixel_index_o, column_o,
//   row_o and last_o (zero unless status is pixel).
//   Push, start and refused requests go from idle to the deliver state and
//   the output register. A pull with pixels stacked reads and pops the
//   stack, then delivers. A pull that must decode reads codes from the bit
//   buffer; past the first code of a table it walks the prefix chain with
//   one registered read of the prefix/suffix RAMs per table entry and then
//   writes the new table entry; it then pops the stack and delivers.
//   in_stall_o is high while a request is in work; the result register lets
//   a new request in while the previous result is still stalled.
//   Reset clears all control state and starts a frame with min code size 8,
//   a 1x1 image and plain row order. Tables are not cleared: entries are
//   always written in a frame before they are read.
//   Configuration writes are accepted at any edge with cfg_we_i high and
//   must be made while the block is idle.
module gif_lzw_pixel_decoder #(
  parameter int TABLE_ENTRIES = gifd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = gifd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  pixel_index_o,
  output logic [15:0] column_o,
  output logic [15:0] row_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import gifd_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int DW = AW + 1;

  state_e state_q, state_d;

  logic [3:0]  mcs_q;
  logic [15:0] img_w_q, img_h_q;
  logic        ilace_q;

  logic [3:0]        cs_q, cs_d, width_q, width_d;
  logic [CODE_W-1:0] next_q, next_d, chain_q, chain_d;
  logic [11:0]       limit_q, limit_d, prev_q, prev_d, cur_q, cur_d;
  logic [7:0]        pfirst_q, pfirst_d, first_q, first_d, sub_q, sub_d;
  logic              havep_q, havep_d, aclr_q, aclr_d;
  logic              ended_q, ended_d, done_q, done_d, err_q, err_d;
  logic [DW-1:0]     depth_q, depth_d;
  res_t              res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  bb_ctl_t     bb_ctl;
  logic [11:0] bb_code;
  logic [5:0]  bb_cnt;

  logic        rs_clear, rs_step, rs_last;
  logic [15:0] rs_col, rs_row;

  logic              tbl_we, stk_we;
  logic [7:0]        stk_wdata, stk_rdata, suf_rdata;
  logic [11:0]       pre_rdata;
  logic [DW-1:0]     depth_m1;

  logic              accept, out_free, enough, need_data, is_clear, is_end;
  logic [CODE_W-1:0] clear_code, dcode, end_code;
  logic              lit_bad, tbl_bad, can_push;
  logic [3:0]        cs_new;
  req_e              req;

  assign req        = req_e'(req_type_i);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clear_code = CODE_W'(1) << cs_q;
  assign end_code   = clear_code + CODE_W'(1);
  assign enough     = bb_cnt >= {2'b00, width_q};
  assign need_data  = !enough && !ended_q;
  assign dcode      = enough ? {1'b0, bb_code} : end_code;
  assign is_clear   = enough && (dcode == clear_code);
  assign is_end     = dcode == end_code;
  assign lit_bad    = dcode >= clear_code;
  assign tbl_bad    = (next_q >= CODE_W'(TABLE_ENTRIES)) || (dcode > next_q);
  assign can_push   = depth_q < DW'(TABLE_ENTRIES);
  assign depth_m1   = depth_q - DW'(1);
  assign cs_new     = (mcs_q < 4'd2) ? 4'd2 : ((mcs_q > 4'd8) ? 4'd8 : mcs_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req == REQ_PULL && !err_q && !done_q) begin
            state_d = (depth_q == '0) ? S_DECODE : S_POP_RD;
          end else begin
            state_d = S_DELIVER;
          end
        end
      end
      S_DECODE: begin
        if (need_data || is_end) state_d = S_DELIVER;
        else if (is_clear) state_d = S_DECODE;
        else if (!havep_q) state_d = lit_bad ? S_DELIVER : S_POP_RD;
        else if (tbl_bad) state_d = S_DELIVER;
        else state_d = S_EXP_RD;
      end
      S_EXP_RD: state_d = (chain_q >= clear_code + CODE_W'(2)) ? S_EXP_WR : S_TABLE_WR;
      S_EXP_WR: state_d = S_EXP_RD;
      S_TABLE_WR: state_d = S_POP_RD;
      S_POP_RD: state_d = S_POP;
      S_POP: state_d = S_DELIVER;
      S_DELIVER: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cs_d = cs_q; width_d = width_q; next_d = next_q; limit_d = limit_q;
    chain_d = chain_q; prev_d = prev_q; cur_d = cur_q; pfirst_d = pfirst_q;
    first_d = first_q; sub_d = sub_q; havep_d = havep_q; aclr_d = aclr_q;
    ended_d = ended_q; done_d = done_q; err_d = err_q; depth_d = depth_q;
    res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    bb_ctl = '{clear: 1'b0, load: 1'b0, take: 1'b0, width: width_q};
    rs_clear = 1'b0; rs_step = 1'b0;
    tbl_we = 1'b0; stk_we = 1'b0; stk_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (req)
            REQ_START: begin
              cs_d = cs_new;
              width_d = cs_new + 4'd1;
              next_d = (CODE_W'(1) << cs_new) + CODE_W'(2);
              limit_d = 12'((13'(1) << (cs_new + 4'd1)) - 13'(1));
              havep_d = 1'b0; aclr_d = 1'b0;
              sub_d = '0; ended_d = 1'b0; done_d = 1'b0; err_d = 1'b0;
              prev_d = '0; pfirst_d = '0; depth_d = '0;
              bb_ctl.clear = 1'b1; rs_clear = 1'b1;
              res_d.status = ST_STARTED;
            end
            REQ_PUSH: begin
              if (ended_q || done_q || err_q) begin
                res_d.status = ST_REFUSED;
              end else if (sub_q == '0) begin
                if (data_byte_i == '0) ended_d = 1'b1;
                else sub_d = data_byte_i;
                res_d.status = ST_TAKEN;
              end else if (bb_cnt > 6'd24) begin
                res_d.status = ST_REFUSED;
              end else begin
                bb_ctl.load = 1'b1;
                sub_d = sub_q - 8'd1;
                res_d.status = ST_TAKEN;
              end
            end
            REQ_PULL: begin
              if (err_q) res_d.status = ST_ERROR;
              else if (done_q) res_d.status = ST_END;
            end
            default: res_d.status = ST_REFUSED;
          endcase
        end
      end
      S_DECODE: begin
        bb_ctl.take = enough;
        if (need_data) begin
          res_d.status = ST_NEED;
        end else if (is_clear) begin
          width_d = cs_q + 4'd1;
          next_d = clear_code + CODE_W'(2);
          limit_d = 12'((13'(1) << (cs_q + 4'd1)) - 13'(1));
          havep_d = 1'b0;
          aclr_d = 1'b1;
        end else if (is_end) begin
          if (aclr_q) begin
            err_d = 1'b1;
            res_d.status = ST_ERROR;
          end else begin
            done_d = 1'b1;
            depth_d = '0;
            res_d.status = ST_END;
          end
        end else if (!havep_q) begin
          if (lit_bad) begin
            err_d = 1'b1;
            res_d.status = ST_ERROR;
          end else begin
            stk_we = can_push;
            stk_wdata = dcode[7:0];
            if (can_push) depth_d = depth_q + DW'(1);
            prev_d = dcode[11:0];
            pfirst_d = dcode[7:0];
            havep_d = 1'b1;
            aclr_d = 1'b0;
          end
        end else if (tbl_bad) begin
          err_d = 1'b1;
          res_d.status = ST_ERROR;
        end else begin
          cur_d = dcode[11:0];
          if (dcode == next_q) begin
            stk_we = can_push;
            stk_wdata = pfirst_q;
            if (can_push) depth_d = depth_q + DW'(1);
            chain_d = {1'b0, prev_q};
          end else begin
            chain_d = dcode;
          end
        end
      end
      S_EXP_RD: begin
        if (chain_q < clear_code + CODE_W'(2)) begin
          stk_we = can_push;
          stk_wdata = chain_q[7:0];
          if (can_push) depth_d = depth_q + DW'(1);
          first_d = chain_q[7:0];
        end
      end
      S_EXP_WR: begin
        stk_we = can_push;
        stk_wdata = suf_rdata;
        if (can_push) depth_d = depth_q + DW'(1);
        chain_d = {1'b0, pre_rdata};
      end
      S_TABLE_WR: begin
        tbl_we = 1'b1;
        next_d = next_q + CODE_W'(1);
        if (next_d > {1'b0, limit_q} && width_q < 4'(MAX_CODE_BITS)) begin
          width_d = width_q + 4'd1;
          limit_d = 12'((13'(1) << (width_q + 4'd1)) - 13'(1));
        end
        prev_d = cur_q;
        pfirst_d = first_q;
      end
      S_POP_RD: depth_d = depth_m1;
      S_POP: begin
        rs_step = 1'b1;
        res_d = '{status: ST_PIXEL, pix: stk_rdata, col: rs_col, row: rs_row,
                  last: rs_last};
        if (rs_last) begin
          done_d = 1'b1;
          depth_d = '0;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          out_d = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mcs_q <= 4'd8; img_w_q <= 16'd1; img_h_q <= 16'd1; ilace_q <= 1'b0;
      cs_q <= 4'd8; width_q <= 4'd9; next_q <= CODE_W'(258); limit_q <= 12'd511;
      prev_q <= '0; pfirst_q <= '0; havep_q <= 1'b0; aclr_q <= 1'b0;
      sub_q <= '0; ended_q <= 1'b0; done_q <= 1'b0; err_q <= 1'b0;
      depth_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_CODE: mcs_q <= cfg_data_i[3:0];
          CFG_WIDTH: img_w_q <= cfg_data_i;
          CFG_HEIGHT: img_h_q <= cfg_data_i;
          default: ilace_q <= cfg_data_i[0];
        endcase
      end
      cs_q <= cs_d; width_q <= width_d; next_q <= next_d; limit_q <= limit_d;
      prev_q <= prev_d; pfirst_q <= pfirst_d; havep_q <= havep_d; aclr_q <= aclr_d;
      sub_q <= sub_d; ended_q <= ended_d; done_q <= done_d; err_q <= err_d;
      depth_q <= depth_d; out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  gifd_bitbuf u_bitbuf (
    .clk_i, .rst_ni, .ctl_i(bb_ctl), .byte_i(data_byte_i),
    .code_o(bb_code), .count_o(bb_cnt)
  );

  gifd_raster u_raster (
    .clk_i, .rst_ni, .clear_i(rs_clear), .step_i(rs_step),
    .width_i(img_w_q), .height_i(img_h_q), .interlaced_i(ilace_q),
    .col_o(rs_col), .row_o(rs_row), .last_o(rs_last)
  );

  gifd_ram #(.WIDTH(CODE_W - 1), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk_i, .we_i(tbl_we), .waddr_i(next_q[AW-1:0]), .wdata_i(prev_q),
    .raddr_i(chain_q[AW-1:0]), .rdata_o(pre_rdata)
  );

  gifd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk_i, .we_i(tbl_we), .waddr_i(next_q[AW-1:0]), .wdata_i(first_q),
    .raddr_i(chain_q[AW-1:0]), .rdata_o(suf_rdata)
  );

  gifd_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(depth_q[AW-1:0]), .wdata_i(stk_wdata),
    .raddr_i(depth_m1[AW-1:0]), .rdata_o(stk_rdata)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign pixel_index_o = out_q.pix;
  assign column_o      = out_q.col;
  assign row_o         = out_q.row;
  assign last_o        = out_q.last;
endmodule

[src/gifd_checker.sv]
// Port-level assertions for the GIF LZW pixel decoder, bound to the top level.
`include "gif_lzw_pixel_decoder_assert.svh"

module gifd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [7:0]  pixel_index_o,
  input logic [15:0] column_o,
  input logic [15:0] row_o,
  input logic        last_o,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [15:0] cfg_data_i
);
  import gifd_pkg::*;

  `GIFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `GIFD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `GIFD_ASSERT_IMPLY(a_last_is_pixel, out_valid_o && last_o, status_o == ST_PIXEL)
  `GIFD_ASSERT_IMPLY(a_nonpixel_zero, out_valid_o && status_o != ST_PIXEL,
                     pixel_index_o == '0 && column_o == '0 && row_o == '0)
endmodule

bind gif_lzw_pixel_decoder gifd_checker u_gifd_checker (.*);

[tb/gif_lzw_pixel_decoder_checker.sv]
// Checker for the GIF LZW pixel decoder: tracks the decoder state and compares every result.
`timescale 1ns / 100ps
module gif_lzw_pixel_decoder_checker
  import gifd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [15:0] column_i,
  input  logic [15:0] row_i,
  input  logic        last_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam int NENT = 4096;

  // configuration copy
  logic [3:0]  min_cs;
  logic [15:0] img_w, img_h;
  logic        ilace;

  // decoder state
  logic [31:0] bbuf;
  int          bcnt, sb_left, cw, nfree, wlimit, prev_code, prev_first, frame_cs;
  bit          ended, have_prev, done, err, after_clr;
  logic [11:0] prefix_mem [NENT];
  logic [7:0]  suffix_mem [NENT];
  logic [7:0]  pix_stack [NENT];
  int          sdepth, col_pos, row_pos, ipass;

  res_t result_q [$];

  assign pending_o = result_q.size();

  function automatic void table_clear();
    cw = frame_cs + 1;
    nfree = (1 << frame_cs) + 2;
    wlimit = (1 << cw) - 1;
    have_prev = 0;
  endfunction

  function automatic void begin_frame();
    int cs;
    cs = min_cs;
    if (cs < 2) cs = 2;
    if (cs > 8) cs = 8;
    frame_cs = cs;
    table_clear();
    bbuf = '0; bcnt = 0; sb_left = 0;
    ended = 0; done = 0; err = 0; after_clr = 0;
    prev_code = 0; prev_first = 0;
    sdepth = 0; col_pos = 0; row_pos = 0; ipass = 0;
  endfunction

  function automatic void stack_push(int v);
    if (sdepth < NENT) begin
      pix_stack[sdepth] = v[7:0];
      sdepth++;
    end
  endfunction

  function automatic int walk_chain(int code, int clr);
    int c, guard;
    c = code;
    guard = 0;
    while (c >= clr + 2 && guard < NENT) begin
      stack_push(suffix_mem[c % NENT]);
      c = prefix_mem[c % NENT];
      guard++;
    end
    c = c & 255;
    stack_push(c);
    return c;
  endfunction

  function automatic status_e next_string();
    int clr, code, first;
    bit at_end;
    while (1) begin
      clr = 1 << frame_cs;
      at_end = 0;
      if (bcnt < cw) begin
        if (!ended) return ST_NEED;
        at_end = 1;
        code = clr + 1;
      end else begin
        code = bbuf & ((32'd1 << cw) - 1);
        bbuf = bbuf >> cw;
        bcnt -= cw;
      end
      if (!at_end && code == clr) begin
        table_clear();
        after_clr = 1;
        continue;
      end
      if (code == clr + 1) begin
        if (after_clr) begin
          err = 1;
          return ST_ERROR;
        end
        done = 1;
        sdepth = 0;
        return ST_END;
      end
      if (!have_prev) begin
        if (code >= clr) begin
          err = 1;
          return ST_ERROR;
        end
        stack_push(code);
        prev_code = code;
        prev_first = code;
        have_prev = 1;
        after_clr = 0;
        return ST_PIXEL;
      end
      if (nfree >= NENT || code > nfree) begin
        err = 1;
        return ST_ERROR;
      end
      if (code == nfree) begin
        stack_push(prev_first);
        first = walk_chain(prev_code, clr);
      end else begin
        first = walk_chain(code, clr);
      end
      prefix_mem[nfree % NENT] = prev_code[11:0];
      suffix_mem[nfree % NENT] = first[7:0];
      nfree++;
      if (nfree > wlimit && cw < 12) begin
        cw++;
        wlimit = (1 << cw) - 1;
      end
      prev_code = code;
      prev_first = first;
      return ST_PIXEL;
    end
  endfunction

  function automatic void step_pos();
    int w, h, r;
    int pstart [4] = '{0, 4, 2, 1};
    int pstep [4] = '{8, 8, 4, 2};
    w = (img_w != 0) ? img_w : 1;
    h = (img_h != 0) ? img_h : 1;
    col_pos++;
    if (col_pos < w) return;
    col_pos = 0;
    if (ilace) begin
      r = row_pos + pstep[ipass & 3];
      while (r >= h) begin
        ipass++;
        if (ipass > 3) begin
          done = 1;
          sdepth = 0;
          return;
        end
        r = pstart[ipass & 3];
      end
    end else begin
      r = row_pos + 1;
      if (r >= h) begin
        done = 1;
        sdepth = 0;
        return;
      end
    end
    row_pos = r & 16'hFFFF;
  endfunction

  function automatic res_t predict_pixel(req_e req, logic [7:0] b);
    res_t r;
    status_e st;
    r = '0;
    if (req == REQ_START) begin
      begin_frame();
      r.status = ST_STARTED;
    end else if (req == REQ_PUSH) begin
      if (ended || done || err) begin
        r.status = ST_REFUSED;
      end else if (sb_left == 0) begin
        if (b == 0) ended = 1;
        else sb_left = b;
        r.status = ST_TAKEN;
      end else if (bcnt > 24) begin
        r.status = ST_REFUSED;
      end else begin
        bbuf = bbuf | (32'(b) << bcnt);
        bcnt += 8;
        sb_left--;
        r.status = ST_TAKEN;
      end
    end else if (req != REQ_PULL) begin
      r.status = ST_REFUSED;
    end else if (err) begin
      r.status = ST_ERROR;
    end else if (done) begin
      r.status = ST_END;
    end else begin
      st = ST_PIXEL;
      if (sdepth == 0) st = next_string();
      if (st != ST_PIXEL) begin
        r.status = st;
      end else begin
        sdepth--;
        r.status = ST_PIXEL;
        r.pix = pix_stack[sdepth % NENT];
        r.col = col_pos[15:0];
        r.row = row_pos[15:0];
        step_pos();
        r.last = done;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      min_cs = 4'd8; img_w = 16'd1; img_h = 16'd1; ilace = 1'b0;
      begin_frame();
      result_q.delete();
      fail_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_CODE: min_cs = cfg_data_i[3:0];
          CFG_WIDTH:    img_w = cfg_data_i;
          CFG_HEIGHT:   img_h = cfg_data_i;
          CFG_ILACE:    ilace = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d", $time, status_i);
          fail_cnt_o++;
        end else begin
          e = result_q.pop_front();
          check_field("status", e.status, status_i);
          check_field("pixel_index", e.pix, pixel_index_i);
          check_field("column", e.col, column_i);
          check_field("row", e.row, row_i);
          check_field("last", e.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        result_q.push_back(predict_pixel(req_e'(req_type_i), data_byte_i));
    end
  end

endmodule

[tb/tb_gif_lzw_pixel_decoder.sv]
// Testbench top of the GIF LZW pixel decoder: stream and pixel-request stimulus and verdict.
`timescale 1ns / 100ps
module tb_gif_lzw_pixel_decoder;
  import gifd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL = 1350;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = REQ_PULL;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  pixel_index;
  logic [15:0] column, row;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_MIN_CODE;
  logic [15:0] cfg_data = 16'd0;
  int          fail_cnt, pending;

  int      n_sent = 0, n_res = 0, cycles = 0, stall_left = 0;
  status_e last_st = ST_NEED;
  logic    last_px = 1'b0;
  bit      quiet = 1'b0;

  // encoder state for building streams
  int          enc_cs, enc_w, enc_nf, enc_nbits;
  bit          enc_have;
  logic [63:0] enc_acc;
  logic [7:0]  raw_q [$];
  logic [7:0]  strm_q [$];

  gif_lzw_pixel_decoder u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .pixel_index_o(pixel_index), .column_o(column),
    .row_o(row), .last_o(last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  gif_lzw_pixel_decoder_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .data_byte_i(data_byte),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .pixel_index_i(pixel_index), .column_i(column),
    .row_i(row), .last_i(last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      n_res <= n_res + 1;
      last_st <= status_e'(status);
      last_px <= last;
    end
  end

  always @(negedge clk_i) begin
    if (cycles % 700 == 0) quiet = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 99) < 15)
        stall_left = ($urandom_range(0, 19) != 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(15, 50);
    end
  end

  task automatic idle_gap();
    int g;
    g = 0;
    if (!quiet && $urandom_range(0, 99) < 25)
      g = ($urandom_range(0, 15) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (g) @(negedge clk_i);
  endtask

  // one transaction in flight: send, wait for acceptance, then for its result
  task automatic send(req_e req, logic [7:0] b);
    idle_gap();
    in_valid = 1'b1;
    req_type = req;
    data_byte = b;
    n_sent++;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
    req_type = 2'($urandom_range(0, 3));
    data_byte = 8'($urandom_range(0, 255));
    while (n_res < n_sent) @(negedge clk_i);
  endtask

  task automatic cfg_wr(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    cfg_data = 16'($urandom_range(0, 65535));
  endtask

  task automatic setup(logic [3:0] cs, logic [15:0] w, logic [15:0] h, logic il);
    cfg_wr(CFG_MIN_CODE, {12'(0), cs});
    cfg_wr(CFG_WIDTH, w);
    cfg_wr(CFG_HEIGHT, h);
    cfg_wr(CFG_ILACE, {15'(0), il});
    enc_cs = (cs < 2) ? 2 : (cs > 8) ? 8 : cs;
    enc_w = enc_cs + 1;
    enc_nf = (1 << enc_cs) + 2;
    enc_have = 0;
    enc_acc = '0;
    enc_nbits = 0;
    raw_q.delete();
    strm_q.delete();
  endtask

  // emits one code at the width the decoder will read it with
  task automatic put_code(int code);
    int clr;
    clr = 1 << enc_cs;
    enc_acc = enc_acc | (64'(code) << enc_nbits);
    enc_nbits += enc_w;
    while (enc_nbits >= 8) begin
      raw_q.push_back(enc_acc[7:0]);
      enc_acc = enc_acc >> 8;
      enc_nbits -= 8;
    end
    if (code == clr) begin
      enc_w = enc_cs + 1;
      enc_nf = clr + 2;
      enc_have = 0;
    end else if (code == clr + 1) begin
    end else if (!enc_have) begin
      enc_have = 1;
    end else begin
      enc_nf++;
      if (enc_nf > (1 << enc_w) - 1 && enc_w < 12) enc_w++;
    end
  endtask

  // splits the packed codes into sub-blocks and adds the terminator if asked
  task automatic pack_stream(bit terminate);
    int n;
    if (enc_nbits > 0) raw_q.push_back(enc_acc[7:0]);
    while (raw_q.size() > 0) begin
      n = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 40);
      if (n > raw_q.size()) n = raw_q.size();
      strm_q.push_back(8'(n));
      repeat (n) strm_q.push_back(raw_q.pop_front());
    end
    if (terminate) strm_q.push_back(8'd0);
  endtask

  task automatic gen_codes(int n, bit lead_clear, bit with_end, bit no_clear);
    int clr, c, r;
    clr = 1 << enc_cs;
    if (lead_clear) put_code(clr);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (!enc_have) c = $urandom_range(0, clr - 1);
      else if ((!no_clear && enc_nf >= 4095) || (!no_clear && r < 3)) c = clr;
      else if (r < 20 && enc_nf < 4096) c = enc_nf;
      else if (r < 60 || enc_nf <= clr + 2) c = $urandom_range(0, clr - 1);
      else c = $urandom_range(clr + 2, enc_nf - 1);
      put_code(c);
    end
    if (with_end) put_code(clr + 1);
  endtask

  // pushes the stream and pulls pixels until the frame finishes or max_tx runs out
  task automatic run_frame(int max_tx);
    int idx, tx;
    bit need, fin;
    send(REQ_START, 8'($urandom_range(0, 255)));
    idx = 0;
    tx = 0;
    need = 0;
    fin = 0;
    while (!fin && tx < max_tx) begin
      tx++;
      if ($urandom_range(0, 49) == 0) begin
        send(REQ_BAD, 8'($urandom_range(0, 255)));
      end else if (idx < strm_q.size() && (need || $urandom_range(0, 2) == 0)) begin
        send(REQ_PUSH, strm_q[idx]);
        if (last_st == ST_TAKEN) idx++;
        need = 0;
      end else begin
        send(REQ_PULL, 8'($urandom_range(0, 255)));
        need = (last_st == ST_NEED);
        fin = (last_st == ST_END) || (last_st == ST_ERROR) ||
              (last_st == ST_PIXEL && last_px);
      end
    end
    send(REQ_PULL, 8'd0);
    send(REQ_PUSH, 8'hFF);
  endtask

  initial begin
    int w, h, cs;
    bit il;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset frame: no data, empty stream, traffic after the end
    send(REQ_PULL, 8'h00);
    send(REQ_PUSH, 8'h00);
    send(REQ_PULL, 8'hFF);
    send(REQ_PUSH, 8'h5A);
    send(REQ_BAD, 8'hA5);

    // smallest code size, repeated clears and the KwKwK case
    setup(4'd1, 16'd3, 16'd3, 1'b0);
    put_code(4); put_code(1); put_code(6); put_code(0);
    put_code(4); put_code(4); put_code(3); put_code(5);
    pack_stream(1);
    run_frame(60);

    // end right after clear
    setup(4'd2, 16'd4, 16'd4, 1'b0);
    put_code(4); put_code(5);
    pack_stream(1);
    run_frame(20);

    // first code not a literal, no leading clear
    setup(4'd3, 16'd4, 16'd4, 1'b0);
    put_code(10);
    pack_stream(1);
    run_frame(20);

    // code beyond the next free entry
    setup(4'd2, 16'd4, 16'd4, 1'b0);
    put_code(4); put_code(1); put_code(9);
    pack_stream(1);
    run_frame(20);

    // widest code size, largest image, stream ends without end code
    setup(4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
    put_code(255); put_code(0); put_code(258);
    pack_stream(1);
    run_frame(40);

    // zero dimensions act as one pixel
    setup(4'd0, 16'd0, 16'd0, 1'b0);
    put_code(4); put_code(3); put_code(2); put_code(5);
    pack_stream(1);
    run_frame(30);

    while (n_sent < ITEM_GOAL) begin
      cs = $urandom_range(0, 15);
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) * 65535 : $urandom_range(1, 12);
      h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
      il = $urandom_range(0, 1);
      setup(4'(cs), 16'(w), 16'(h), il);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 40)) strm_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) strm_q.push_back(8'd0);
      end else begin
        gen_codes($urandom_range(5, 60), $urandom_range(0, 4) != 0,
                  $urandom_range(0, 4) != 0, 0);
        pack_stream(1);
      end
      run_frame(3 * strm_q.size() + ((w * h > 200 || w * h == 0) ? 200 : w * h) + 50);
    end

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
